// ===== rtl/buddy_page_allocator_defines.svh =====
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define BPA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define BPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;
    localparam int DEF_MAX_LEVEL = 10;
    localparam int LVL_W         = 4;
    localparam logic [LVL_W-1:0] USED_MARK = 4'hF;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/bpa_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface bpa_req_if #(parameter int MAX_LEVEL = bpa_pkg::DEF_MAX_LEVEL);
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [MAX_LEVEL:0]   page_count;
    logic [MAX_LEVEL-1:0] page_offset;
    modport source (output valid, command, page_count, page_offset, input ready);
    modport sink (input valid, command, page_count, page_offset, output ready);
endinterface

interface bpa_rsp_if #(parameter int MAX_LEVEL = bpa_pkg::DEF_MAX_LEVEL);
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [MAX_LEVEL-1:0] alloc_offset;
    logic [MAX_LEVEL:0]   avail_pages;
    modport source (output valid, status, alloc_offset, avail_pages, input ready);
    modport sink (input valid, status, alloc_offset, avail_pages, output ready);
endinterface
`default_nettype wire

// ===== rtl/bpa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bpa_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 2047
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/bpa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bpa_ctrl #(
    parameter int MAX_LEVEL = bpa_pkg::DEF_MAX_LEVEL
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [bpa_pkg::LVL_W-1:0]  i_cfg_wdata,
    input  wire logic                       i_req_valid,
    output logic                            o_req_ready,
    input  wire logic                       i_command,
    input  wire logic [MAX_LEVEL:0]         i_page_count,
    input  wire logic [MAX_LEVEL-1:0]       i_page_offset,
    output logic                            o_res_valid,
    input  wire logic                       i_res_ready,
    output logic [1:0]                      o_res_status,
    output logic [MAX_LEVEL-1:0]            o_res_offset,
    output logic [MAX_LEVEL:0]              o_res_free,
    output logic                            o_mem_we,
    output logic [MAX_LEVEL:0]              o_mem_waddr,
    output logic [bpa_pkg::LVL_W-1:0]       o_mem_wdata,
    output logic [MAX_LEVEL:0]              o_mem_raddr,
    input  wire logic [bpa_pkg::LVL_W-1:0]  i_mem_rdata
);
    import bpa_pkg::*;

    localparam int NODE_W = MAX_LEVEL + 1;
    localparam int CNT_W  = MAX_LEVEL + 1;
    localparam int OFF_W  = MAX_LEVEL;
    localparam int RST_LVL_I = (10 > MAX_LEVEL) ? MAX_LEVEL : 10;
    localparam logic [LVL_W-1:0] RST_LEVEL = LVL_W'(RST_LVL_I);
    localparam logic [LVL_W-1:0] TOP_LEVEL = LVL_W'(MAX_LEVEL);

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_EVAL, S_DL, S_DR, S_DD,
        S_FILL, S_UP, S_AL, S_AR, S_AW, S_REPLY
    } t_state;

    t_state            r_state;
    logic [LVL_W-1:0]  r_tl;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_cmd;
    logic [LVL_W-1:0]  r_k;
    logic [LVL_W-1:0]  r_lvl;
    logic [NODE_W-1:0] r_node;
    logic [NODE_W-1:0] r_first;
    logic [NODE_W-1:0] r_i;
    logic [LVL_W-1:0]  r_d;
    logic [LVL_W-1:0]  r_fval;
    logic              r_used;
    logic              r_build;
    logic [LVL_W-1:0]  r_l;
    logic [1:0]        r_status;
    logic [OFF_W-1:0]  r_off;

    // Round a count up to the next power of two and return its log2
    function automatic logic [LVL_W-1:0] round_level(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] m;
        logic [LVL_W-1:0] k;
        m = n - CNT_W'(1);
        k = '0;
        for (int b = 0; b < CNT_W; b++) begin
            if (m[b]) begin
                k = LVL_W'(b + 1);
            end
        end
        return k;
    endfunction

    function automatic logic [LVL_W-1:0] larger(input logic [LVL_W-1:0] a,
                                                input logic [LVL_W-1:0] b);
        if (a == USED_MARK) return b;
        if (b == USED_MARK) return a;
        return (a > b) ? a : b;
    endfunction

    logic [LVL_W-1:0]  k_in;
    logic [LVL_W-1:0]  cfg_lvl;
    logic [NODE_W-1:0] free_node;
    logic [NODE_W-1:0] child_l;
    logic [NODE_W-1:0] child_r;
    logic              lfit;
    logic              rfit;
    logic [NODE_W-1:0] dd_node;
    logic [NODE_W-1:0] fill_node;
    logic [NODE_W-1:0] off_full;
    logic [OFF_W-1:0]  alloc_off;
    logic [NODE_W-1:0] last_i;
    logic              fill_done;
    logic [LVL_W-1:0]  merge_val;
    logic [LVL_W-1:0]  lvl_dn;

    // Request decode
    assign k_in    = round_level(i_page_count);
    assign cfg_lvl = (i_cfg_wdata > TOP_LEVEL) ? TOP_LEVEL : i_cfg_wdata;
    assign free_node = (NODE_W'(i_page_offset) >> k_in)
                     + (NODE_W'(1) << (r_tl - k_in)) - NODE_W'(1);

    // Child selection on the way down
    assign child_l = NODE_W'({r_node, 1'b1});
    assign child_r = NODE_W'({r_node, 1'b1}) + NODE_W'(1);
    assign lfit    = (r_l != USED_MARK) && (r_l >= r_k);
    assign rfit    = (i_mem_rdata != USED_MARK) && (i_mem_rdata >= r_k);
    assign dd_node = (lfit && rfit) ? ((r_l > i_mem_rdata) ? child_r : child_l)
                   : (lfit ? child_l : child_r);
    assign lvl_dn  = r_lvl - LVL_W'(1);

    // Page offset of the block that is taken
    assign fill_node = (r_state == S_DD) ? dd_node : r_node;
    assign off_full  = ((fill_node + NODE_W'(1)) << r_k) - (NODE_W'(1) << r_tl);
    assign alloc_off = off_full[OFF_W-1:0];

    // Subtree sweep bookkeeping
    assign last_i    = (NODE_W'(1) << r_d) - NODE_W'(1);
    assign fill_done = (r_d == r_k) && (r_i == last_i);

    // Parent value on the way up: merge buddies or take the larger child
    assign merge_val = ((r_l == lvl_dn) && (i_mem_rdata == lvl_dn)) ? r_lvl
                     : larger(r_l, i_mem_rdata);

    // Memory access
    always_comb begin
        o_mem_we    = (r_state == S_FILL) || (r_state == S_AW);
        o_mem_waddr = (r_state == S_FILL) ? (r_first + r_i) : r_node;
        o_mem_wdata = (r_state == S_FILL) ? r_fval : merge_val;
        case (r_state)
            S_DL, S_AL: o_mem_raddr = child_l;
            S_DR, S_AR: o_mem_raddr = child_r;
            default:    o_mem_raddr = r_node;
        endcase
    end

    assign o_req_ready  = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_REPLY);
    assign o_res_status = r_status;
    assign o_res_offset = r_off;
    assign o_res_free   = r_cnt;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_FILL;
            r_tl     <= RST_LEVEL;
            r_cnt    <= CNT_W'(1) << RST_LEVEL;
            r_k      <= RST_LEVEL;
            r_node   <= '0;
            r_first  <= '0;
            r_i      <= '0;
            r_d      <= '0;
            r_fval   <= RST_LEVEL;
            r_used   <= 1'b0;
            r_build  <= 1'b1;
            r_status <= ST_DONE;
            r_off    <= '0;
        end else if (i_cfg_we) begin
            // Rebuild the whole tree as free
            r_state <= S_FILL;
            r_tl    <= cfg_lvl;
            r_cnt   <= CNT_W'(1) << cfg_lvl;
            r_k     <= cfg_lvl;
            r_node  <= '0;
            r_first <= '0;
            r_i     <= '0;
            r_d     <= '0;
            r_fval  <= cfg_lvl;
            r_used  <= 1'b0;
            r_build <= 1'b1;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_cmd   <= i_command;
                        r_k     <= k_in;
                        r_off   <= '0;
                        r_build <= 1'b0;
                        if (i_command == CMD_ALLOC) begin
                            if (i_page_count == '0) begin
                                r_status <= ST_INVALID;
                                r_state  <= S_REPLY;
                            end else if (i_page_count > r_cnt || k_in > r_tl) begin
                                r_status <= ST_NOSPACE;
                                r_state  <= S_REPLY;
                            end else begin
                                r_node  <= '0;
                                r_lvl   <= r_tl;
                                r_state <= S_CHK;
                            end
                        end else begin
                            if (i_page_count == '0 || k_in > r_tl
                                || {1'b0, i_page_offset} >= (CNT_W'(1) << r_tl)) begin
                                r_status <= ST_INVALID;
                                r_state  <= S_REPLY;
                            end else begin
                                r_node  <= free_node;
                                r_lvl   <= k_in;
                                r_state <= S_CHK;
                            end
                        end
                    end
                end
                S_CHK: r_state <= S_EVAL;
                S_EVAL: begin
                    r_first <= r_node;
                    r_i     <= '0;
                    r_d     <= '0;
                    if (r_cmd == CMD_ALLOC) begin
                        if (i_mem_rdata == USED_MARK || i_mem_rdata < r_k) begin
                            r_status <= ST_NOSPACE;
                            r_state  <= S_REPLY;
                        end else if (r_lvl == r_k) begin
                            r_off   <= alloc_off;
                            r_fval  <= USED_MARK;
                            r_used  <= 1'b1;
                            r_state <= S_FILL;
                        end else begin
                            r_state <= S_DL;
                        end
                    end else begin
                        if (i_mem_rdata != USED_MARK) begin
                            r_status <= ST_INVALID;
                            r_state  <= S_REPLY;
                        end else begin
                            r_fval  <= r_k;
                            r_used  <= 1'b0;
                            r_state <= S_FILL;
                        end
                    end
                end
                S_DL: r_state <= S_DR;
                S_DR: begin
                    r_l     <= i_mem_rdata;
                    r_state <= S_DD;
                end
                S_DD: begin
                    // Step to the tighter fitting child
                    r_node <= dd_node;
                    r_lvl  <= lvl_dn;
                    if (lvl_dn == r_k) begin
                        r_off   <= alloc_off;
                        r_first <= dd_node;
                        r_i     <= '0;
                        r_d     <= '0;
                        r_fval  <= USED_MARK;
                        r_used  <= 1'b1;
                        r_state <= S_FILL;
                    end else begin
                        r_state <= S_DL;
                    end
                end
                S_FILL: begin
                    if (fill_done) begin
                        r_state <= r_build ? S_IDLE : S_UP;
                    end else if (r_i == last_i) begin
                        r_i     <= '0;
                        r_d     <= r_d + LVL_W'(1);
                        r_first <= NODE_W'({r_first, 1'b1});
                        if (!r_used) begin
                            r_fval <= r_fval - LVL_W'(1);
                        end
                    end else begin
                        r_i <= r_i + NODE_W'(1);
                    end
                end
                S_UP: begin
                    if (r_node == '0) begin
                        r_status <= ST_DONE;
                        if (r_cmd == CMD_ALLOC) begin
                            r_cnt <= r_cnt - (CNT_W'(1) << r_k);
                        end else begin
                            r_cnt <= r_cnt + (CNT_W'(1) << r_k);
                        end
                        r_state <= S_REPLY;
                    end else begin
                        r_node  <= (r_node - NODE_W'(1)) >> 1;
                        r_lvl   <= r_lvl + LVL_W'(1);
                        r_state <= S_AL;
                    end
                end
                S_AL: r_state <= S_AR;
                S_AR: begin
                    r_l     <= i_mem_rdata;
                    r_state <= S_AW;
                end
                S_AW: r_state <= S_UP;
                S_REPLY: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/buddy_page_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Fields
// i_req     in   command, page_count, page_offset
// o_rsp     out  status, alloc_offset, avail_pages
// i_cfg_*   in   total_level (write only)
//
// One request at a time; the tree lives in a single RAM with registered reads.
// A request is rejected either on decode or after the root or node read.
// Otherwise the root or node is read, an alloc walks down level by level,
// the chosen subtree is swept, and each ancestor is rewritten on the way up.
// After reset or a total_level write the whole tree is swept as free,
// and i_req.ready stays low until that sweep is done.
// A result waits in the output register; the sequencer waits in its reply
// state while that register is full and o_rsp is stalled.
module buddy_page_allocator
    `include "buddy_page_allocator_defines.svh"
#(
    parameter int MAX_LEVEL = bpa_pkg::DEF_MAX_LEVEL
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [bpa_pkg::LVL_W-1:0] i_cfg_wdata,
    bpa_req_if.sink                        i_req,
    bpa_rsp_if.source                      o_rsp
);
    import bpa_pkg::*;

    localparam int NODE_W = MAX_LEVEL + 1;
    localparam int DEPTH  = (2 << MAX_LEVEL) - 1;

    logic              res_valid;
    logic              res_ready;
    logic [1:0]        res_status;
    logic [MAX_LEVEL-1:0] res_offset;
    logic [MAX_LEVEL:0]   res_free;
    logic              mem_we;
    logic [NODE_W-1:0] mem_waddr;
    logic [LVL_W-1:0]  mem_wdata;
    logic [NODE_W-1:0] mem_raddr;
    logic [LVL_W-1:0]  mem_rdata;
    logic              r_valid;
    logic [1:0]        r_status;
    logic [MAX_LEVEL-1:0] r_offset;
    logic [MAX_LEVEL:0]   r_free;

    bpa_ram #(.WIDTH(LVL_W), .DEPTH(DEPTH)) u_tree (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bpa_ctrl #(.MAX_LEVEL(MAX_LEVEL)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_valid   (i_req.valid),
        .o_req_ready   (i_req.ready),
        .i_command     (i_req.command),
        .i_page_count  (i_req.page_count),
        .i_page_offset (i_req.page_offset),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res_status  (res_status),
        .o_res_offset  (res_offset),
        .o_res_free    (res_free),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata)
    );

    // Hold the result word until the sink takes it
    assign res_ready = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (res_ready) begin
            r_valid <= res_valid;
        end
        if (res_valid && res_ready) begin
            r_status <= res_status;
            r_offset <= res_offset;
            r_free   <= res_free;
        end
    end

    assign o_rsp.valid        = r_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.alloc_offset = r_offset;
    assign o_rsp.avail_pages  = r_free;

    `BPA_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready, "request accepted while busy")
    `BPA_ASSERT_NOW(a_offset_zero, i_clk, i_rst_n, o_rsp.valid && o_rsp.status != ST_DONE, o_rsp.alloc_offset == '0, "offset set on failed request")
    `BPA_ASSERT_NOW(a_no_idle_write, i_clk, i_rst_n, mem_we, !i_req.ready, "tree written while idle")
    `BPA_ASSERT_NOW(a_free_bound, i_clk, i_rst_n, o_rsp.valid, o_rsp.avail_pages <= ((MAX_LEVEL + 1)'(1) << MAX_LEVEL), "free count above tree size")
endmodule
`default_nettype wire
